@@ design/assert_macros.svh @@
// Assertion helpers included by the execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tiex_pkg.sv @@
`default_nettype none
package tiex_pkg;

    // Fixed sizes of the state.
    localparam int NUM_REGS  = 32;
    localparam int MEM_BYTES = 1024;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int BANKS     = 8;
    localparam int ROWS      = MEM_BYTES / BANKS;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int REG_AW    = $clog2(NUM_REGS);

    // Instruction categories.
    localparam logic [2:0] CAT_XFER  = 3'd0;
    localparam logic [2:0] CAT_ARITH = 3'd1;
    localparam logic [2:0] CAT_LOGIC = 3'd2;
    localparam logic [2:0] CAT_CTRL  = 3'd3;
    localparam logic [2:0] CAT_CMP   = 3'd4;

    // Transfer subops.
    localparam logic [4:0] SUB_LDR_ABS = 5'd0;
    localparam logic [4:0] SUB_LDR_REG = 5'd1;
    localparam logic [4:0] SUB_STR     = 5'd2;
    localparam logic [4:0] SUB_MOV     = 5'd3;

    // Arithmetic subops.
    localparam logic [5:0] SUB_ADD  = 6'd0;
    localparam logic [5:0] SUB_SUB  = 6'd1;
    localparam logic [5:0] SUB_MUL  = 6'd2;
    localparam logic [5:0] SUB_ADDI = 6'd3;
    localparam logic [5:0] SUB_SUBI = 6'd4;

    // Logic subops.
    localparam logic [5:0] SUB_AND = 6'd0;
    localparam logic [5:0] SUB_ORR = 6'd1;
    localparam logic [5:0] SUB_EOR = 6'd2;
    localparam logic [5:0] SUB_LSL = 6'd3;
    localparam logic [5:0] SUB_LSR = 6'd4;

    // Compare subops.
    localparam logic [5:0] SUB_CMP  = 6'd0;
    localparam logic [5:0] SUB_CMN  = 6'd1;
    localparam logic [5:0] SUB_CMPI = 6'd2;
    localparam logic [5:0] SUB_TST  = 6'd3;

    // Control subops and conditions.
    localparam logic [3:0] SUB_B  = 4'd0;
    localparam logic [3:0] SUB_BL = 4'd1;
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_LT = 4'hb;

    localparam logic [4:0] LINK_REG   = 5'd30;
    localparam logic [5:0] SHIFT_MASK = 6'h3F;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_BAD   = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

endpackage
`default_nettype wire

@@ design/toy_isa_execute_unit.sv @@
// Channel   Direction  Ports                                  Beat
// s_        in         s_valid s_ready s_kind s_instruction   one instruction or restart
// m_        out        m_valid m_ready m_pc_after ...         one result per instruction or restart
// cfg_      in         cfg_valid cfg_ready cfg_data           register seed write
//
// Simple instructions finish in S_EXEC; the next beat is accepted as one finishes.
// Loads pass through S_EXEC and S_LOAD for the registered read of the eight byte banks.
// MUL runs from S_EXEC through S_MUL: one 32x32 multiplier is used three times for the low 64 bits.
// A restart finishes in S_EXEC and then starts a clearing pass over all 128 memory rows;
// the same pass runs after reset. No beat is accepted during it.
// A result waiting on m_ready holds the finishing instruction, and with it s_ready.
`default_nettype none
`include "assert_macros.svh"
module toy_isa_execute_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [31:0] s_instruction,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_pc_after,
    output logic             m_flag_z,
    output logic             m_flag_n,
    output logic             m_reg_written,
    output logic      [4:0]  m_write_index,
    output logic      [63:0] m_write_value,
    output logic      [1:0]  m_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data
);
    import tiex_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_MUL
    } state_t;

    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
    localparam logic [MEM_AW-1:0] ADDR_LAST = MEM_AW'(MEM_BYTES - 8);

    state_t              state_reg;
    logic                kind_reg;
    logic [31:0]         ir_reg;
    logic [ROW_AW-1:0]   clr_cnt_reg;
    logic [1:0]          mstep_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         seed_reg;
    logic [63:0]         rseed_reg;
    logic [NUM_REGS-1:0] rf_vld_reg;
    logic                fwd_vld_reg;
    logic [REG_AW-1:0]   fwd_idx_reg;
    logic [63:0]         fwd_val_reg;
    logic [63:0]         pc_reg;
    logic                flag_z_reg;
    logic                flag_n_reg;
    logic                m_valid_reg;
    logic [63:0]         m_pc_reg;
    logic                m_z_reg;
    logic                m_n_reg;
    logic                m_wr_reg;
    logic [4:0]          m_idx_reg;
    logic [63:0]         m_val_reg;
    logic [1:0]          m_status_reg;

    logic              accept;
    logic              out_free;
    logic [REG_AW-1:0] rf_ra;
    logic [REG_AW-1:0] rf_rb;
    logic [63:0]       ram_a_q;
    logic [63:0]       ram_b_q;
    logic [63:0]       val_a;
    logic [63:0]       val_b;
    logic [63:0]       val_rd;

    // Instruction fields of the item at work.
    logic [2:0]  cat;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [4:0]  rb;
    logic [4:0]  sub5;
    logic [11:0] imm_x;
    logic [5:0]  sub6;
    logic [11:0] imm_a;
    logic [5:0]  shamt;
    logic [3:0]  sub4;
    logic [3:0]  cond;
    logic [63:0] br_off;

    logic [MEM_AW-1:0] mem_addr;
    logic [2:0]        mem_off;
    logic              mem_fits;
    logic [63:0]       ld_val;
    logic              bank_we;
    logic [ROW_AW-1:0] bank_row [BANKS];
    logic [7:0]        bank_wd  [BANKS];
    logic [7:0]        bank_q   [BANKS];

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [63:0] mul_sum;

    logic        fin_wr;
    logic [4:0]  fin_idx;
    logic [63:0] fin_val;
    logic [1:0]  fin_status;
    logic        fin_z;
    logic        fin_n;
    logic [63:0] fin_pc;
    logic        fin_store;
    logic        fin_restart;
    logic        goes_load;
    logic        goes_mul;
    logic        take;
    logic        fin_here;
    logic        complete;

    // Port B reads rd for an unknown logic subop, whose flags follow rd.
    function automatic logic [4:0] port_b_sel(input logic [31:0] w);
        logic [4:0] sel;
        sel = w[14:10];
        if (w[31:29] == CAT_LOGIC && w[28:23] > SUB_LSR) begin
            sel = w[4:0];
        end
        return sel;
    endfunction

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) || (complete && !fin_restart);
    assign accept    = s_valid && s_ready;

    // Decode of the held instruction.
    assign cat    = ir_reg[31:29];
    assign rd     = ir_reg[4:0];
    assign rn     = ir_reg[9:5];
    assign rb     = port_b_sel(ir_reg);
    assign sub5   = ir_reg[28:24];
    assign imm_x  = ir_reg[23:12];
    assign sub6   = ir_reg[28:23];
    assign imm_a  = ir_reg[26:15];
    assign shamt  = ir_reg[21:16] & SHIFT_MASK;
    assign sub4   = ir_reg[28:25];
    assign cond   = ir_reg[22:19];
    assign br_off = {{43{ir_reg[18]}}, ir_reg[18:0], 2'b00};

    // Register file: two copies written alike, one per read port.
    assign rf_ra = accept ? s_instruction[9:5] : rn;
    assign rf_rb = accept ? port_b_sel(s_instruction) : rb;

    tiex_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_a (
        .clk(aclk), .we(complete && fin_wr), .waddr(fin_idx), .wdata(fin_val),
        .raddr(rf_ra), .rdata(ram_a_q)
    );

    tiex_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_b (
        .clk(aclk), .we(complete && fin_wr), .waddr(fin_idx), .wdata(fin_val),
        .raddr(rf_rb), .rdata(ram_b_q)
    );

    // Operands: forward the write that landed with this read, else RAM or restart value.
    always_comb begin
        if (fwd_vld_reg && fwd_idx_reg == rn) begin
            val_a = fwd_val_reg;
        end else if (rf_vld_reg[rn]) begin
            val_a = ram_a_q;
        end else begin
            val_a = rseed_reg + 64'(rn);
        end
        if (fwd_vld_reg && fwd_idx_reg == rb) begin
            val_b = fwd_val_reg;
        end else if (rf_vld_reg[rb]) begin
            val_b = ram_b_q;
        end else begin
            val_b = rseed_reg + 64'(rb);
        end
    end
    assign val_rd = val_b;

    // Byte address and range check.
    assign mem_addr = (sub5 == SUB_LDR_ABS) ? imm_x[MEM_AW-1:0]
                                            : val_a[MEM_AW-1:0] + imm_x[MEM_AW-1:0];
    assign mem_off  = mem_addr[2:0];
    assign mem_fits = mem_addr <= ADDR_LAST;

    // Eight byte banks; a bank below the start byte holds its byte in the next row.
    assign bank_we = (state_reg == S_CLEAR) || (complete && fin_store);

    for (genvar k = 0; k < BANKS; k++) begin : g_bank
        logic [2:0]        st_sel;
        logic [ROW_AW-1:0] row;
        assign st_sel = 3'(k) - mem_off;
        assign row    = mem_addr[MEM_AW-1:3] + ROW_AW'(3'(k) < mem_off);
        assign bank_row[k] = (state_reg == S_CLEAR) ? clr_cnt_reg : row;
        assign bank_wd[k]  = (state_reg == S_CLEAR) ? 8'd0 : val_b[8*st_sel +: 8];

        tiex_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .clk(aclk), .we(bank_we), .waddr(bank_row[k]), .wdata(bank_wd[k]),
            .raddr(row), .rdata(bank_q[k])
        );
    end

    // Little-endian gather of the loaded bytes.
    always_comb begin
        for (int j = 0; j < BANKS; j++) begin
            ld_val[8*j +: 8] = bank_q[3'(mem_off + 3'(j))];
        end
    end

    // Shared 32x32 multiplier: low*low, then both cross terms into the upper half.
    assign mul_x   = (mstep_reg == 2'd2) ? val_a[63:32] : val_a[31:0];
    assign mul_y   = (mstep_reg == 2'd1) ? val_b[63:32] : val_b[31:0];
    assign mul_p   = 64'(mul_x) * 64'(mul_y);
    assign mul_sum = acc_reg + {mul_p[31:0], 32'd0};

    // Execute: outcome of the item in its finishing cycle.
    always_comb begin
        fin_wr      = 1'b0;
        fin_idx     = 5'd0;
        fin_val     = 64'd0;
        fin_status  = STAT_OK;
        fin_z       = flag_z_reg;
        fin_n       = flag_n_reg;
        fin_pc      = pc_reg + 64'd4;
        fin_store   = 1'b0;
        fin_restart = 1'b0;
        goes_load   = 1'b0;
        goes_mul    = 1'b0;
        take        = 1'b0;
        if (state_reg == S_LOAD) begin
            fin_wr  = 1'b1;
            fin_idx = rd;
            fin_val = ld_val;
        end else if (state_reg == S_MUL) begin
            fin_wr  = 1'b1;
            fin_idx = rd;
            fin_val = mul_sum;
            fin_z   = (mul_sum == 64'd0);
            fin_n   = mul_sum[63];
        end else if (kind_reg) begin
            fin_restart = 1'b1;
            fin_pc      = 64'd0;
            fin_z       = 1'b0;
            fin_n       = 1'b0;
        end else begin
            unique case (cat)
                CAT_XFER: begin
                    unique case (sub5)
                        SUB_LDR_ABS, SUB_LDR_REG: begin
                            if (mem_fits) begin
                                goes_load = 1'b1;
                            end else begin
                                fin_wr     = 1'b1;
                                fin_idx    = rd;
                                fin_status = STAT_RANGE;
                            end
                        end
                        SUB_STR: begin
                            if (mem_fits) begin
                                fin_store = 1'b1;
                            end else begin
                                fin_status = STAT_RANGE;
                            end
                        end
                        SUB_MOV: begin
                            fin_wr  = 1'b1;
                            fin_idx = rd;
                            fin_val = val_a;
                        end
                        default: fin_status = STAT_BAD;
                    endcase
                end
                CAT_ARITH: begin
                    fin_wr  = 1'b1;
                    fin_idx = rd;
                    unique case (sub6)
                        SUB_ADD:  fin_val = val_a + val_b;
                        SUB_SUB:  fin_val = val_a - val_b;
                        SUB_MUL:  goes_mul = 1'b1;
                        SUB_ADDI: fin_val = val_a + 64'(imm_a);
                        SUB_SUBI: fin_val = val_a - 64'(imm_a);
                        default: begin
                            fin_wr     = 1'b0;
                            fin_idx    = 5'd0;
                            fin_status = STAT_BAD;
                        end
                    endcase
                    if (fin_wr) begin
                        fin_z = (fin_val == 64'd0);
                        fin_n = fin_val[63];
                    end
                end
                CAT_LOGIC: begin
                    fin_wr  = 1'b1;
                    fin_idx = rd;
                    unique case (sub6)
                        SUB_AND: fin_val = val_a & val_b;
                        SUB_ORR: fin_val = val_a | val_b;
                        SUB_EOR: fin_val = val_a ^ val_b;
                        SUB_LSL: fin_val = val_a << shamt;
                        SUB_LSR: fin_val = val_a >> shamt;
                        default: begin
                            fin_wr     = 1'b0;
                            fin_idx    = 5'd0;
                            fin_status = STAT_BAD;
                        end
                    endcase
                    fin_z = fin_wr ? (fin_val == 64'd0) : (val_rd == 64'd0);
                    fin_n = fin_wr ? fin_val[63] : val_rd[63];
                end
                CAT_CTRL: begin
                    unique case (sub4)
                        SUB_B: take = 1'b1;
                        SUB_BL: begin
                            take    = 1'b1;
                            fin_wr  = 1'b1;
                            fin_idx = LINK_REG;
                            fin_val = pc_reg;
                        end
                        default: begin
                            unique case (cond)
                                COND_EQ: take = flag_z_reg;
                                COND_NE: take = !flag_z_reg;
                                COND_LT: take = flag_n_reg;
                                default: fin_status = STAT_BAD;
                            endcase
                        end
                    endcase
                    fin_pc = pc_reg + (take ? br_off + 64'd4 : 64'd4);
                end
                CAT_CMP: begin
                    unique case (sub6)
                        SUB_CMP: fin_val = val_a - val_b;
                        SUB_CMN: fin_val = val_a + val_b;
                        SUB_CMPI: fin_val = val_a - 64'(imm_a);
                        SUB_TST: fin_val = val_a & val_b;
                        default: fin_status = STAT_BAD;
                    endcase
                    if (fin_status == STAT_OK) begin
                        fin_z = (fin_val == 64'd0);
                        fin_n = fin_val[63];
                    end
                    fin_val = 64'd0;
                end
                default: fin_status = STAT_BAD;
            endcase
        end
    end

    assign fin_here = (state_reg == S_EXEC && !goes_load && !goes_mul) ||
                      (state_reg == S_LOAD) ||
                      (state_reg == S_MUL && mstep_reg == 2'd2);
    assign complete = fin_here && out_free;

    // Sequencer, architectural state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            mstep_reg    <= 2'd0;
            seed_reg     <= 64'd0;
            rseed_reg    <= 64'd0;
            rf_vld_reg   <= '0;
            fwd_vld_reg  <= 1'b0;
            pc_reg       <= 64'd0;
            flag_z_reg   <= 1'b0;
            flag_n_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
            if (m_ready && !complete) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                kind_reg <= s_kind;
                ir_reg   <= s_instruction;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ROW_LAST) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC, S_LOAD, S_MUL: begin
                    if (state_reg == S_EXEC && goes_load) begin
                        state_reg <= S_LOAD;
                    end else if (state_reg == S_EXEC && goes_mul) begin
                        state_reg <= S_MUL;
                        mstep_reg <= 2'd0;
                    end else if (state_reg == S_MUL && mstep_reg != 2'd2) begin
                        mstep_reg <= mstep_reg + 2'd1;
                        acc_reg   <= (mstep_reg == 2'd0) ? mul_p : mul_sum;
                    end else if (complete) begin
                        pc_reg        <= fin_pc;
                        flag_z_reg    <= fin_z;
                        flag_n_reg    <= fin_n;
                        m_valid_reg   <= 1'b1;
                        m_pc_reg      <= fin_pc;
                        m_z_reg       <= fin_z;
                        m_n_reg       <= fin_n;
                        m_wr_reg      <= fin_wr;
                        m_idx_reg     <= fin_idx;
                        m_val_reg     <= fin_val;
                        m_status_reg  <= fin_status;
                        // A restart never writes a register, so this also drops forwarding.
                        fwd_vld_reg   <= fin_wr;
                        fwd_idx_reg   <= fin_idx;
                        fwd_val_reg   <= fin_val;
                        if (fin_wr) begin
                            rf_vld_reg[fin_idx] <= 1'b1;
                        end
                        if (fin_restart) begin
                            rf_vld_reg  <= '0;
                            rseed_reg   <= seed_reg;
                            clr_cnt_reg <= '0;
                            state_reg   <= S_CLEAR;
                        end else if (accept) begin
                            state_reg <= S_EXEC;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pc_after    = m_pc_reg;
    assign m_flag_z      = m_z_reg;
    assign m_flag_n      = m_n_reg;
    assign m_reg_written = m_wr_reg;
    assign m_write_index = m_idx_reg;
    assign m_write_value = m_val_reg;
    assign m_status      = m_status_reg;

    // Checks on the sequencer.
    `ASSERT_CLK_RST(a_no_accept_clear, aclk, aresetn, (state_reg == S_CLEAR) |-> !s_ready, "beat accepted during clearing pass")
    `ASSERT_CLK_RST(a_restart_clears, aclk, aresetn, (complete && fin_restart) |=> (state_reg == S_CLEAR), "restart did not start clearing pass")
    `ASSERT_CLK_RST(a_ready_needs_slot, aclk, aresetn, (s_ready && state_reg != S_IDLE) |-> out_free, "finish accepted with result slot full")
    `ASSERT_CLK(a_no_write_in_load, aclk, (aresetn && state_reg == S_LOAD) |-> !bank_we, "bank write during load")

endmodule
`default_nettype wire

@@ design/tiex_ram.sv @@
`default_nettype none
module tiex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on a collision).
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
